### hw/rtl/double_to_int32_safety_check_macros.svh
// Assertion macros for the binary64 to int32 checker.
// Included by the top level; no other dependencies.
`ifndef DOUBLE_TO_INT32_SAFETY_CHECK_MACROS_SVH
`define DOUBLE_TO_INT32_SAFETY_CHECK_MACROS_SVH
`ifndef NO_ASSERTIONS
`define D2I_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define D2I_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("check");
`else
`define D2I_ASSERT_IMPL(label, clk, rst, prop)
`define D2I_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

### hw/rtl/d2i_pkg.sv
// Package for the binary64 to int32 checker: class codes and the not-available value code.
// No dependencies.
`default_nettype none
package d2i_pkg;
   localparam logic [1:0] CLS_UNSAFE  = 2'd0;
   localparam logic [1:0] CLS_EXACT   = 2'd1;
   localparam logic [1:0] CLS_MISSING = 2'd2;
   localparam logic [31:0] NA_CODE    = 32'h8000_0000;
endpackage
`default_nettype wire

### hw/rtl/d2i_req_if.sv
// Valid/ready channel interface for request words.
// No dependencies.
`default_nettype none
interface d2i_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] value_bits;
   logic        last_item;
   modport source (output valid, value_bits, last_item, input ready);
   modport sink   (input valid, value_bits, last_item, output ready);
endinterface
`default_nettype wire

### hw/rtl/d2i_rsp_if.sv
// Response channel interface.
// No dependencies.
`default_nettype none
interface d2i_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] converted_value;
   logic [1:0]  element_class;
   logic [1:0]  verdict;
   logic        verdict_final;
   modport source (output valid, converted_value, element_class, verdict, verdict_final,
                   input ready);
   modport sink   (input valid, converted_value, element_class, verdict, verdict_final,
                   output ready);
endinterface
`default_nettype wire

### hw/rtl/double_to_int32_safety_check.sv
// Binary64 to int32 exactness checker: one word per cycle at full rate. A word
// accepted into the input register is decoded between the input register and
// the result register, which drives the response channel; a held result
// stalls the input only once both registers are occupied. The verdict is sticky
// per vector and returns to "all exact" after the word marked last.
// Depends on d2i_pkg, the channel interfaces and the macros header.
`default_nettype none
`include "double_to_int32_safety_check_macros.svh"
module double_to_int32_safety_check
   import d2i_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   d2i_req_if.sink   req,
   d2i_rsp_if.source rsp
);
   logic        in_vld_ff;
   logic [63:0] in_bits_ff;
   logic        in_last_ff;
   logic        out_vld_ff;
   logic [31:0] out_val_ff;
   logic [1:0]  out_cls_ff;
   logic [1:0]  out_ver_ff;
   logic        out_fin_ff;
   logic [1:0]  verdict_ff;
   logic [1:0]  verdict_in;
   logic        adv;
   logic        out_free;
   logic [10:0] expo;
   logic [51:0] frac;
   logic [52:0] mant;
   logic [5:0]  shift;
   logic [52:0] low_mask;
   logic [52:0] mag;
   logic [1:0]  cls;
   logic [31:0] val;
   logic [10:0] e_rel;

   // stage 1 moves on when the result register is empty or being taken
   assign out_free  = !out_vld_ff || rsp.ready;
   assign adv       = in_vld_ff && out_free;
   assign req.ready = !in_vld_ff || out_free;

   // decode
   always_comb begin
      expo     = in_bits_ff[62:52];
      frac     = in_bits_ff[51:0];
      mant     = {1'b1, frac};
      e_rel    = expo - 11'd1023;
      shift    = 6'd52 - e_rel[5:0];
      low_mask = (53'd1 << shift) - 53'd1;
      mag      = mant >> shift;
      cls      = CLS_UNSAFE;
      val      = NA_CODE;
      if (expo == 11'h7FF) begin
         cls = (frac != 52'd0) ? CLS_MISSING : CLS_UNSAFE;
      end else if (expo == 11'd0) begin
         if (frac == 52'd0) begin
            cls = CLS_EXACT;
            val = 32'd0;
         end
      end else if (expo >= 11'd1023 && expo < 11'd1054) begin
         if ((mant & low_mask) == 53'd0) begin
            cls = CLS_EXACT;
            val = in_bits_ff[63] ? 32'd0 - mag[31:0] : mag[31:0];
         end
      end
   end

   // sticky verdict
   always_comb begin
      verdict_in = verdict_ff;
      if (cls == CLS_UNSAFE) begin
         verdict_in = 2'd0;
      end else if (cls == CLS_MISSING && verdict_ff != 2'd0) begin
         verdict_in = 2'd2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         verdict_ff <= 2'd1;
      end else begin
         if (req.valid && req.ready) begin
            in_vld_ff <= 1'b1;
         end else if (adv) begin
            in_vld_ff <= 1'b0;
         end
         if (adv) begin
            out_vld_ff <= 1'b1;
            verdict_ff <= in_last_ff ? 2'd1 : verdict_in;
         end else if (rsp.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_bits_ff <= req.value_bits;
         in_last_ff <= req.last_item;
      end
      if (adv) begin
         out_val_ff <= val;
         out_cls_ff <= cls;
         out_ver_ff <= verdict_in;
         out_fin_ff <= in_last_ff;
      end
   end

   assign rsp.valid           = out_vld_ff;
   assign rsp.converted_value = out_val_ff;
   assign rsp.element_class   = out_cls_ff;
   assign rsp.verdict         = out_ver_ff;
   assign rsp.verdict_final   = out_fin_ff;

   `D2I_ASSERT_NEXT(a_stall_hold, clock, reset, out_vld_ff && !rsp.ready, out_vld_ff)
   `D2I_ASSERT_NEXT(a_last_clear, clock, reset, adv && in_last_ff, verdict_ff == 2'd1)
   `D2I_ASSERT_NEXT(a_unsafe_zero, clock, reset, adv && cls == CLS_UNSAFE, out_ver_ff == 2'd0)
endmodule
`default_nettype wire
